@@ hdl/uti_pkg.sv @@
package uti_pkg;

  // Decoder modes. Codes five to seven behave as idle.
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_BODY = 3'd1;
  localparam logic [2:0] M_ESC  = 3'd2;
  localparam logic [2:0] M_XHEX = 3'd3;
  localparam logic [2:0] M_UHEX = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_CLOSED  = 3'd1;
  localparam logic [2:0] ST_NEWLINE = 3'd2;
  localparam logic [2:0] ST_ENDESC  = 3'd3;
  localparam logic [2:0] ST_BADX    = 3'd4;
  localparam logic [2:0] ST_BADU    = 3'd5;
  localparam logic [2:0] ST_UNTERM  = 3'd6;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_U     = 8'h75;

  // UTF-8 encoding constants.
  localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF_CONT      = 8'h80;
  localparam logic [7:0]  UTF_MASK      = 8'h3F;
  localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;

  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       source_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // All results caused by one input request, handed from decoder to emitter.
  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [2:0]                  status;
  } bundle_t;

  // Returns {1'b0, value} for a hex digit, or 5'h10 for anything else.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d_lo;
    logic [7:0] d_up;
    d_lo = c - 8'h57;
    d_up = c - 8'h37;
    if (c inside {[8'h30:8'h39]}) begin
      return {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      return {1'b0, d_lo[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      return {1'b0, d_up[3:0]};
    end else begin
      return 5'h10;
    end
  endfunction

endpackage

@@ hdl/uti_if.sv @@
interface uti_in_if;
  import uti_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uti_out_if;
  import uti_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/uti_decode.sv @@
module uti_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  uti_pkg::in_item_t item,
  output uti_pkg::bundle_t  bnd
);
  import uti_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [4:0]  hv;
  logic [15:0] shifted;

  assign hv      = hex_value(item.source_byte);
  assign shifted = {acc_r[11:0], hv[3:0]};

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    digits_nxt = digits_r;
    bnd        = '0;
    bnd.status = ST_BUSY;
    case (mode_r)
      M_BODY: begin
        if (item.source_end || item.source_byte == CH_QUOTE ||
            item.source_byte == CH_NL) begin
          mode_nxt   = M_IDLE;
          acc_nxt    = '0;
          digits_nxt = '0;
          bnd.cnt    = 2'd1;
          if (item.source_end) begin
            bnd.status = ST_UNTERM;
          end else if (item.source_byte == CH_QUOTE) begin
            bnd.status = ST_CLOSED;
          end else begin
            bnd.status = ST_NEWLINE;
          end
        end else if (item.source_byte == CH_BSL) begin
          mode_nxt = M_ESC;
        end else begin
          bnd.cnt      = 2'd1;
          bnd.bytes[0] = item.source_byte;
        end
      end
      M_ESC: begin
        if (item.source_end) begin
          mode_nxt   = M_IDLE;
          acc_nxt    = '0;
          digits_nxt = '0;
          bnd.cnt    = 2'd1;
          bnd.status = ST_ENDESC;
        end else begin
          mode_nxt = M_BODY;
          case (item.source_byte)
            CH_N: begin
              bnd.cnt      = 2'd1;
              bnd.bytes[0] = CH_NL;
            end
            CH_R: begin
              bnd.cnt      = 2'd1;
              bnd.bytes[0] = CH_CR;
            end
            CH_T: begin
              bnd.cnt      = 2'd1;
              bnd.bytes[0] = CH_TAB;
            end
            CH_X: begin
              mode_nxt   = M_XHEX;
              acc_nxt    = '0;
              digits_nxt = '0;
            end
            CH_U: begin
              mode_nxt   = M_UHEX;
              acc_nxt    = '0;
              digits_nxt = '0;
            end
            default: begin
              bnd.cnt      = 2'd1;
              bnd.bytes[0] = item.source_byte;
            end
          endcase
        end
      end
      M_XHEX, M_UHEX: begin
        if (item.source_end || hv[4]) begin
          mode_nxt   = M_IDLE;
          acc_nxt    = '0;
          digits_nxt = '0;
          bnd.cnt    = 2'd1;
          bnd.status = (mode_r == M_XHEX) ? ST_BADX : ST_BADU;
        end else begin
          acc_nxt = shifted;
          if (mode_r == M_XHEX && digits_r != 2'd0) begin
            mode_nxt     = M_BODY;
            digits_nxt   = '0;
            bnd.cnt      = 2'd1;
            bnd.bytes[0] = shifted[7:0];
          end else if (mode_r == M_UHEX && digits_r == 2'd3) begin
            mode_nxt   = M_BODY;
            digits_nxt = '0;
            if (shifted[15:7] == 9'd0) begin
              bnd.cnt      = 2'd1;
              bnd.bytes[0] = shifted[7:0];
            end else if (shifted < UTF_TWO_LIMIT) begin
              bnd.cnt      = 2'd2;
              bnd.bytes[0] = UTF_LEAD2 | {3'd0, shifted[10:6]};
              bnd.bytes[1] = UTF_CONT | ({2'd0, shifted[5:0]} & UTF_MASK);
            end else begin
              bnd.cnt      = 2'd3;
              bnd.bytes[0] = UTF_LEAD3 | {4'd0, shifted[15:12]};
              bnd.bytes[1] = UTF_CONT | ({2'd0, shifted[11:6]} & UTF_MASK);
              bnd.bytes[2] = UTF_CONT | ({2'd0, shifted[5:0]} & UTF_MASK);
            end
          end else begin
            digits_nxt = digits_r + 2'd1;
          end
        end
      end
      default: begin
        if (!item.source_end) begin
          mode_nxt   = M_BODY;
          acc_nxt    = '0;
          digits_nxt = '0;
        end else begin
          mode_nxt = M_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      acc_r    <= '0;
      digits_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      digits_r <= digits_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.source_end |=> mode_r == M_IDLE)
    else $error("source end did not return the decoder to idle");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    bnd.status != ST_BUSY |-> bnd.cnt == 2'd1)
    else $error("error or close status with other than one result");

  a_xhex_digits: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_XHEX |-> digits_r <= 2'd1)
    else $error("too many digits counted in a hex byte escape");
`endif

endmodule

@@ hdl/uti_emit.sv @@
module uti_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  uti_pkg::bundle_t   bnd,
  output logic               can_load,
  output logic               res_valid,
  input  logic               res_ready,
  output uti_pkg::out_item_t res
);
  import uti_pkg::*;

  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [MAX_RESULTS-1:0][7:0] byte_r, byte_nxt;
  logic [2:0]                  status_r, status_nxt;
  logic                        pop;

  assign res_valid = rem_r != '0;
  assign pop       = res_valid && res_ready;
  // The register frees up when empty or when its final result leaves now.
  assign can_load  = (rem_r == '0) || (rem_r == CNT_W'(1) && res_ready);

  assign res.out_byte  = byte_r[0];
  assign res.out_valid = status_r == ST_BUSY;
  assign res.status    = status_r;
  assign res.last      = rem_r == CNT_W'(1);

  always_comb begin
    rem_nxt    = rem_r;
    byte_nxt   = byte_r;
    status_nxt = status_r;
    if (load) begin
      rem_nxt    = bnd.cnt;
      byte_nxt   = bnd.bytes;
      status_nxt = bnd.status;
    end else if (pop) begin
      rem_nxt  = rem_r - CNT_W'(1);
      byte_nxt = byte_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
  end

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r > CNT_W'(1) |-> !can_load)
    else $error("new request admitted while several results remain");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !load |=> rem_r == $past(rem_r) - CNT_W'(1))
    else $error("result count did not step down after a pop");

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && status_r != ST_BUSY |-> rem_r == CNT_W'(1))
    else $error("error or close result not alone");
`endif

endmodule

@@ hdl/string_literal_unescaper_top.sv @@
// Output is registered: a result appears in the cycle after its request is accepted.
// Throughput: one input request per cycle while the output is ready; a request that
// yields two or three UTF-8 bytes holds the input while the output register drains.
// Reset: synchronous, active low; the decoder returns to idle and the output
// register is emptied.
module string_literal_unescaper_top (
  input logic       clk,
  input logic       rst_n,
  uti_in_if.sink    in_chan,
  uti_out_if.source out_chan
);
  import uti_pkg::*;

  // A request is accepted whenever the output register can take all of its
  // results, which includes the cycle in which its final pending result leaves.
  logic    accept;
  logic    can_load;
  bundle_t bnd;

  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid && can_load;

  // The decoder holds the literal's mode, the hex accumulator and the digit
  // count, and produces every result of the current request combinationally, together.
  uti_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_chan.data),
    .bnd    (bnd)
  );

  // The emitter registers the results and hands them out one per transfer on
  // the output channel, marking the final one of each input request.
  uti_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .bnd       (bnd),
    .can_load  (can_load),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res       (out_chan.data)
  );

endmodule
